[sv/mia_pkg.sv]
// mia_pkg: shared types, constants and width helpers of the monopole
// interaction accumulator. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mia_pkg;

    // field widths fixed by the item format
    localparam int OFS_W   = 5;
    localparam int MASS_W  = 32;
    localparam int SCALE_W = 32;
    localparam int ACC_W   = 48;

    // fixed point: Q16.16 factors and scales
    localparam int FRAC_W      = 16;
    localparam int FACT_STEPS  = FRAC_W + 2;       // root bits of the factor search
    localparam int BOUND_SHIFT = 2 * FRAC_W + 2;   // 2^34 in the factor bound
    localparam int FMAG_W      = FRAC_W + 1;       // factor magnitude, up to 1.0
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_W;

    // accumulator components
    localparam int N_COMP = 4;
    localparam int COMP_W = 2;
    localparam logic [COMP_W-1:0] COMP_POTENTIAL  = 2'd0;
    localparam logic [COMP_W-1:0] COMP_GRADIENT_X = 2'd1;
    localparam logic [COMP_W-1:0] COMP_GRADIENT_Y = 2'd2;
    localparam logic [COMP_W-1:0] COMP_GRADIENT_Z = 2'd3;

    typedef enum logic [0:0] {
        REG_SCALE_MONOPOLE = 1'b0,
        REG_SCALE_DIPOLE   = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUBE_SQ,
        ST_CUBE,
        ST_FACT_START,
        ST_FACT_WAIT,
        ST_SCALE_MUL,
        ST_SCALE_RND,
        ST_TERM_LO,
        ST_TERM_HI,
        ST_TERM_RND,
        ST_ACCUM,
        ST_EMIT
    } t_back_state;

    // width of a clamped offset magnitude
    function automatic int mag_width(input int max_ofs);
        return $clog2(max_ofs + 1);
    endfunction

    // width of the squared distance
    function automatic int d2_width(input int max_ofs);
        return $clog2(3 * max_ofs * max_ofs + 1);
    endfunction

endpackage

`default_nettype wire

[sv/monopole_interaction_accumulator.sv]
// monopole_interaction_accumulator: top level; config registers, front,
// queue and back. Depends on mia_pkg, mia_front, mia_queue and mia_back.
`timescale 1ns / 1ps
`default_nettype none

// Accumulates monopole potential and gradient terms over the stencil
// partners of one target cell. Each input transfer is one partner: a small
// offset, clamped to +-MAX_OFFSET, and four signed Q16.16 expansion
// components. The block forms -1/r and x/r^3, y/r^3, z/r^3 in Q16.16 (all
// zero for a zero offset), scales component zero by scale_monopole and the
// others by scale_dipole, and adds the products into four saturating 48-bit
// Q32.16 sums. first clears the sums and the clip flag before the partner is
// added; last sends one result transfer with the sums after it is added.
// The sums are kept after a result until the next first.
// Per component, the 18-step root search for the factor in the back end
// (one bit per cycle) sets the pace; the d2^3 term, the scaling and the
// 48-bit term products all go through one shared 32x32 multiplier. A
// QUEUE_DEPTH entry queue in front of the back end and the result
// register let input transfers and result transfers proceed while the
// back end is busy.
// Config writes are always ready and must be made while the block is idle.
module monopole_interaction_accumulator #(
    parameter int MAX_OFFSET  = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // partner input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mia_pkg::OFS_W-1:0]    i_offset_x,
    input  logic signed [mia_pkg::OFS_W-1:0]    i_offset_y,
    input  logic signed [mia_pkg::OFS_W-1:0]    i_offset_z,
    input  logic signed [mia_pkg::MASS_W-1:0]   i_mass_zero,
    input  logic signed [mia_pkg::MASS_W-1:0]   i_mass_one,
    input  logic signed [mia_pkg::MASS_W-1:0]   i_mass_two,
    input  logic signed [mia_pkg::MASS_W-1:0]   i_mass_three,
    input  logic                                i_first,
    input  logic                                i_last,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mia_pkg::ACC_W-1:0]    o_potential_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_x_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_y_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_z_sum,
    output logic                                o_saturated,
    // config write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  mia_pkg::t_reg_index                 i_cfg_index,
    input  logic [mia_pkg::SCALE_W-1:0]         i_cfg_data
);
    import mia_pkg::*;

    localparam int MAG_W = mag_width(MAX_OFFSET);
    localparam int SQ_W  = 2 * MAG_W;
    localparam int D2_W  = d2_width(MAX_OFFSET);

    // queue word layout, lsb first
    localparam int OFS_SQX   = 3;
    localparam int OFS_SQY   = OFS_SQX + SQ_W;
    localparam int OFS_SQZ   = OFS_SQY + SQ_W;
    localparam int OFS_D2    = OFS_SQZ + SQ_W;
    localparam int OFS_M0    = OFS_D2 + D2_W;
    localparam int OFS_M1    = OFS_M0 + MASS_W;
    localparam int OFS_M2    = OFS_M1 + MASS_W;
    localparam int OFS_M3    = OFS_M2 + MASS_W;
    localparam int OFS_LAST  = OFS_M3 + MASS_W;
    localparam int OFS_FIRST = OFS_LAST + 1;
    localparam int Q_W       = OFS_FIRST + 1;

    logic [SCALE_W-1:0] r_scale_monopole, r_scale_dipole;

    t_q_status          q_status;
    logic               q_push, q_pop;
    logic [Q_W-1:0]     q_wdata, q_rdata;

    logic [2:0]         f_neg;
    logic [SQ_W-1:0]    f_sq_x, f_sq_y, f_sq_z;
    logic [D2_W-1:0]    f_d2;

    // config registers, to be written only while idle; the block does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_monopole <= SCALE_RESET;
            r_scale_dipole   <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCALE_MONOPOLE: r_scale_monopole <= i_cfg_data;
                REG_SCALE_DIPOLE:   r_scale_dipole   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: classify the partner and push it into the queue
    mia_front #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_front (
        .i_valid    (i_in_valid),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (q_push),
        .i_offset_x (i_offset_x),
        .i_offset_y (i_offset_y),
        .i_offset_z (i_offset_z),
        .o_neg      (f_neg),
        .o_sq_x     (f_sq_x),
        .o_sq_y     (f_sq_y),
        .o_sq_z     (f_sq_z),
        .o_d2       (f_d2)
    );

    assign q_wdata = {i_first, i_last,
                      i_mass_three, i_mass_two, i_mass_one, i_mass_zero,
                      f_d2, f_sq_z, f_sq_y, f_sq_x, f_neg};

    // decoupling queue, holds classified partners while the back is busy
    mia_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wdata  (q_wdata),
        .i_pop    (q_pop),
        .o_rdata  (q_rdata),
        .o_status (q_status)
    );

    // back: factors, products, sums and the result register; the head entry
    // stays in the queue until its last component is added
    mia_back #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_status       (q_status),
        .o_pop            (q_pop),
        .i_neg            (q_rdata[2:0]),
        .i_sq_x           (q_rdata[OFS_SQX +: SQ_W]),
        .i_sq_y           (q_rdata[OFS_SQY +: SQ_W]),
        .i_sq_z           (q_rdata[OFS_SQZ +: SQ_W]),
        .i_d2             (q_rdata[OFS_D2 +: D2_W]),
        .i_mass_zero      (q_rdata[OFS_M0 +: MASS_W]),
        .i_mass_one       (q_rdata[OFS_M1 +: MASS_W]),
        .i_mass_two       (q_rdata[OFS_M2 +: MASS_W]),
        .i_mass_three     (q_rdata[OFS_M3 +: MASS_W]),
        .i_first          (q_rdata[OFS_FIRST]),
        .i_last           (q_rdata[OFS_LAST]),
        .i_scale_monopole (r_scale_monopole),
        .i_scale_dipole   (r_scale_dipole),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_potential_sum  (o_potential_sum),
        .o_gradient_x_sum (o_gradient_x_sum),
        .o_gradient_y_sum (o_gradient_y_sum),
        .o_gradient_z_sum (o_gradient_z_sum),
        .o_saturated      (o_saturated)
    );

endmodule

`default_nettype wire

[sv/mia_front.sv]
// mia_front: input handshake and item classification (offset clamp, signs,
// squares, squared distance). Depends on mia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mia_front #(
    parameter int MAX_OFFSET = 8,
    localparam int MAG_W = mia_pkg::mag_width(MAX_OFFSET),
    localparam int SQ_W  = 2 * MAG_W,
    localparam int D2_W  = mia_pkg::d2_width(MAX_OFFSET)
) (
    input  logic                              i_valid,
    input  mia_pkg::t_q_status                i_q_status,
    output logic                              o_stall,
    output logic                              o_push,
    input  logic signed [mia_pkg::OFS_W-1:0]  i_offset_x,
    input  logic signed [mia_pkg::OFS_W-1:0]  i_offset_y,
    input  logic signed [mia_pkg::OFS_W-1:0]  i_offset_z,
    output logic [2:0]                        o_neg,
    output logic [SQ_W-1:0]                   o_sq_x,
    output logic [SQ_W-1:0]                   o_sq_y,
    output logic [SQ_W-1:0]                   o_sq_z,
    output logic [D2_W-1:0]                   o_d2
);
    import mia_pkg::*;

    localparam int EXT_W = OFS_W + 2;
    localparam logic signed [EXT_W-1:0] LIMIT = EXT_W'(MAX_OFFSET);

    logic signed [OFS_W-1:0] ofs     [3];
    logic signed [EXT_W-1:0] ofs_ext [3];
    logic signed [EXT_W-1:0] clamped [3];
    logic signed [EXT_W-1:0] absval  [3];
    logic [MAG_W-1:0]        mag     [3];
    logic [SQ_W-1:0]         sq      [3];

    assign ofs[0] = i_offset_x;
    assign ofs[1] = i_offset_y;
    assign ofs[2] = i_offset_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ofs_ext[k] = EXT_W'(ofs[k]);
            if (ofs_ext[k] > LIMIT) begin
                clamped[k] = LIMIT;
            end else if (ofs_ext[k] < -LIMIT) begin
                clamped[k] = -LIMIT;
            end else begin
                clamped[k] = ofs_ext[k];
            end
            o_neg[k]  = clamped[k][EXT_W-1];
            absval[k] = o_neg[k] ? -clamped[k] : clamped[k];
            mag[k]    = absval[k][MAG_W-1:0];
            sq[k]     = SQ_W'(mag[k]) * SQ_W'(mag[k]);
        end
    end

    assign o_sq_x = sq[0];
    assign o_sq_y = sq[1];
    assign o_sq_z = sq[2];
    assign o_d2   = D2_W'(sq[0]) + D2_W'(sq[1]) + D2_W'(sq[2]);

    // input stalls only on a full queue
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

endmodule

`default_nettype wire

[sv/mia_queue.sv]
// mia_queue: short register fifo between the front and the back.
// Depends on mia_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module mia_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_wdata,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_rdata,
    output mia_pkg::t_q_status o_status
);
    import mia_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

[sv/mia_factor.sv]
// mia_factor: bit-serial search for the largest t with t*t*M <= B, one
// root bit per cycle with add/compare only. Depends on mia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mia_factor #(
    parameter int M_W = 30,
    parameter int B_W = 44
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [M_W-1:0]                 i_m,
    input  logic [B_W-1:0]                 i_b,
    output logic                           o_done,
    output logic [mia_pkg::FACT_STEPS-1:0] o_root
);
    import mia_pkg::*;

    localparam int W = M_W + 2 * FACT_STEPS + 2;

    logic                  r_busy, r_done;
    logic [FACT_STEPS-1:0] r_bit, r_root;
    logic [W-1:0]          r_p, r_u, r_v;
    logic [B_W-1:0]        r_b;
    logic [W-1:0]          cand;
    logic                  fit;

    // p = root^2*M, u = root*M << (k+1), v = M << 2k for the current bit k
    assign cand = r_p + r_u + r_v;
    assign fit  = (cand <= W'(r_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit  <= {1'b1, {(FACT_STEPS-1){1'b0}}};
            r_root <= '0;
            r_p    <= '0;
            r_u    <= '0;
            r_v    <= W'(i_m) << (2 * (FACT_STEPS - 1));
            r_b    <= i_b;
        end else if (r_busy) begin
            if (fit) begin
                r_p    <= cand;
                r_root <= r_root | r_bit;
                r_u    <= (r_u + (r_v << 1)) >> 1;
            end else begin
                r_u    <= r_u >> 1;
            end
            r_v   <= r_v >> 2;
            r_bit <= r_bit >> 1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[sv/mia_back.sv]
// mia_back: sequencer that computes the four factors, scales and multiplies
// on one shared multiplier, and keeps the saturating sums and result register.
// Depends on mia_pkg and mia_factor.
`timescale 1ns / 1ps
`default_nettype none

module mia_back #(
    parameter int MAX_OFFSET = 8,
    localparam int MAG_W  = mia_pkg::mag_width(MAX_OFFSET),
    localparam int SQ_W   = 2 * MAG_W,
    localparam int D2_W   = mia_pkg::d2_width(MAX_OFFSET)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mia_pkg::t_q_status                  i_q_status,
    output logic                                o_pop,
    input  logic [2:0]                          i_neg,
    input  logic [SQ_W-1:0]                     i_sq_x,
    input  logic [SQ_W-1:0]                     i_sq_y,
    input  logic [SQ_W-1:0]                     i_sq_z,
    input  logic [D2_W-1:0]                     i_d2,
    input  logic [mia_pkg::MASS_W-1:0]          i_mass_zero,
    input  logic [mia_pkg::MASS_W-1:0]          i_mass_one,
    input  logic [mia_pkg::MASS_W-1:0]          i_mass_two,
    input  logic [mia_pkg::MASS_W-1:0]          i_mass_three,
    input  logic                                i_first,
    input  logic                                i_last,
    input  logic [mia_pkg::SCALE_W-1:0]         i_scale_monopole,
    input  logic [mia_pkg::SCALE_W-1:0]         i_scale_dipole,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mia_pkg::ACC_W-1:0]    o_potential_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_x_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_y_sum,
    output logic signed [mia_pkg::ACC_W-1:0]    o_gradient_z_sum,
    output logic                                o_saturated
);
    import mia_pkg::*;

    localparam int CUBE_W = 3 * D2_W;
    localparam int B_W    = SQ_W + BOUND_SHIFT;
    localparam int SUM_W  = ACC_W + 2;

    t_back_state r_state, n_state;

    logic [COMP_W-1:0]     r_comp;
    logic [PROD_W-1:0]     r_prod, r_plo;
    logic [CUBE_W-1:0]     r_cube;
    logic [FMAG_W-1:0]     r_fmag;
    logic [ACC_W-1:0]      r_scaled, r_term;
    logic [ACC_W-1:0]      r_sum [N_COMP];
    logic                  r_clip;
    logic                  r_out_valid;
    logic [ACC_W-1:0]      r_out_sum [N_COMP];
    logic                  r_out_sat;

    // sequencer outputs
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     prod;
    logic                  fact_start, out_load, comp_last;

    // per-component selection
    logic [MASS_W-1:0]     mass_sel, mass_mag;
    logic [SCALE_W-1:0]    scale_sel;
    logic [SQ_W-1:0]       sq_sel;
    logic                  mneg, fneg;
    logic [CUBE_W-1:0]     fact_m;
    logic [B_W-1:0]        fact_b;
    logic                  fact_done;
    logic [FACT_STEPS-1:0] fact_root;
    logic [FACT_STEPS:0]   root_inc;

    logic [PROD_W-1:0]     rnd_scale, rnd_term;
    logic [ACC_W-1:0]      acc_cur;
    logic [SUM_W-1:0]      acc_ext, term_ext, sum_ext;
    logic                  ovf;
    logic [ACC_W-1:0]      acc_new;

    assign comp_last = (r_comp == COMP_GRADIENT_Z);

    always_comb begin
        case (r_comp)
            COMP_POTENTIAL: begin
                mass_sel  = i_mass_zero;
                scale_sel = i_scale_monopole;
                sq_sel    = '0;
                fneg      = 1'b1;
            end
            COMP_GRADIENT_X: begin
                mass_sel  = i_mass_one;
                scale_sel = i_scale_dipole;
                sq_sel    = i_sq_x;
                fneg      = i_neg[0];
            end
            COMP_GRADIENT_Y: begin
                mass_sel  = i_mass_two;
                scale_sel = i_scale_dipole;
                sq_sel    = i_sq_y;
                fneg      = i_neg[1];
            end
            default: begin
                mass_sel  = i_mass_three;
                scale_sel = i_scale_dipole;
                sq_sel    = i_sq_z;
                fneg      = i_neg[2];
            end
        endcase
    end

    assign mneg     = mass_sel[MASS_W-1];
    assign mass_mag = mneg ? (~mass_sel + 1'b1) : mass_sel;

    // 1/r: t^2*d2 <= 2^34, c/r^3: t^2*d2^3 <= c^2*2^34
    assign fact_m = (r_comp == COMP_POTENTIAL) ? CUBE_W'(i_d2) : r_cube;
    assign fact_b = (r_comp == COMP_POTENTIAL) ? (B_W'(1) << BOUND_SHIFT)
                                                : (B_W'(sq_sel) << BOUND_SHIFT);

    mia_factor #(
        .M_W (CUBE_W),
        .B_W (B_W)
    ) u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fact_start),
        .i_m     (fact_m),
        .i_b     (fact_b),
        .o_done  (fact_done),
        .o_root  (fact_root)
    );

    // round half up on the search root gives the factor magnitude
    assign root_inc = {1'b0, fact_root} + 1'b1;

    // shared multiplier
    assign prod = {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_b};

    assign rnd_scale = r_prod + ROUND_HALF;
    assign rnd_term  = r_plo + {r_prod[MUL_W-1:0], {MUL_W{1'b0}}} + ROUND_HALF;

    // saturating add of the signed term
    assign acc_cur  = r_sum[r_comp];
    assign acc_ext  = {{2{acc_cur[ACC_W-1]}}, acc_cur};
    assign term_ext = {2'b00, r_term};
    assign sum_ext  = (mneg ^ fneg) ? (acc_ext - term_ext) : (acc_ext + term_ext);
    assign ovf      = (sum_ext[SUM_W-1:ACC_W-1] != 3'b000)
                   && (sum_ext[SUM_W-1:ACC_W-1] != 3'b111);
    assign acc_new  = !ovf ? sum_ext[ACC_W-1:0]
                   : (sum_ext[SUM_W-1] ? ACC_MIN : ACC_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (!i_q_status.empty) n_state = ST_CUBE_SQ;
            ST_CUBE_SQ:    n_state = ST_CUBE;
            ST_CUBE:       n_state = ST_FACT_START;
            ST_FACT_START: n_state = ST_FACT_WAIT;
            ST_FACT_WAIT:  if (fact_done) n_state = ST_SCALE_MUL;
            ST_SCALE_MUL:  n_state = ST_SCALE_RND;
            ST_SCALE_RND:  n_state = ST_TERM_LO;
            ST_TERM_LO:    n_state = ST_TERM_HI;
            ST_TERM_HI:    n_state = ST_TERM_RND;
            ST_TERM_RND:   n_state = ST_ACCUM;
            ST_ACCUM: begin
                if (!comp_last) begin
                    n_state = ST_FACT_START;
                end else if (i_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT:       if (out_load) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        fact_start = 1'b0;
        o_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_CUBE_SQ: begin
                mul_a = MUL_W'(i_d2);
                mul_b = MUL_W'(i_d2);
            end
            ST_CUBE: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(i_d2);
            end
            ST_FACT_START: fact_start = 1'b1;
            ST_SCALE_MUL: begin
                mul_a = mass_mag;
                mul_b = scale_sel;
            end
            ST_TERM_LO: begin
                mul_a = r_scaled[MUL_W-1:0];
                mul_b = MUL_W'(r_fmag);
            end
            ST_TERM_HI: begin
                mul_a = MUL_W'(r_scaled[ACC_W-1:MUL_W]);
                mul_b = MUL_W'(r_fmag);
            end
            ST_ACCUM:   o_pop = comp_last;
            ST_EMIT:    out_load = !r_out_valid || !i_out_stall;
            ST_IDLE, ST_FACT_WAIT, ST_SCALE_RND, ST_TERM_RND: ;
            default: ;
        endcase
    end

    // control state, sums and clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_comp      <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_COMP; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && !i_q_status.empty) begin
                r_comp <= COMP_POTENTIAL;
                if (i_first) begin
                    r_clip <= 1'b0;
                    for (int k = 0; k < N_COMP; k++) begin
                        r_sum[k] <= '0;
                    end
                end
            end
            if (r_state == ST_ACCUM) begin
                r_sum[r_comp] <= acc_new;
                if (ovf) begin
                    r_clip <= 1'b1;
                end
                r_comp <= r_comp + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CUBE_SQ:   r_prod <= prod;
            ST_CUBE:      r_cube <= prod[CUBE_W-1:0];
            ST_FACT_WAIT: begin
                if (fact_done) begin
                    r_fmag <= (i_d2 == '0) ? '0 : root_inc[FMAG_W:1];
                end
            end
            ST_SCALE_MUL: r_prod   <= prod;
            ST_SCALE_RND: r_scaled <= rnd_scale[FRAC_W +: ACC_W];
            ST_TERM_LO:   r_plo    <= prod;
            ST_TERM_HI:   r_prod   <= prod;
            ST_TERM_RND:  r_term   <= rnd_term[FRAC_W +: ACC_W];
            ST_IDLE, ST_FACT_START, ST_ACCUM, ST_EMIT: ;
            default: ;
        endcase
        if (out_load) begin
            for (int k = 0; k < N_COMP; k++) begin
                r_out_sum[k] <= r_sum[k];
            end
            r_out_sat <= r_clip;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_potential_sum  = r_out_sum[COMP_POTENTIAL];
    assign o_gradient_x_sum = r_out_sum[COMP_GRADIENT_X];
    assign o_gradient_y_sum = r_out_sum[COMP_GRADIENT_Y];
    assign o_gradient_z_sum = r_out_sum[COMP_GRADIENT_Z];
    assign o_saturated      = r_out_sat;

endmodule

`default_nettype wire
